// ===== rtl/core/ftgc_pkg.sv =====
// Shared widths, register codes and the output rounding for the gravity compensation block.
`default_nettype none
package ftgc_pkg;

   // Pipeline depth from the accepted request to the response strobe.
   localparam int LATENCY = 5;

   localparam int SMP_W  = 16;          // sensor sample and Q1.14 operand width
   localparam int QP_W   = 32;          // quaternion product
   localparam int ROT_W  = 34;          // rotation entry, Q.28
   localparam int DIFF_W = 17;          // offset-removed sample
   localparam int GW_W   = 33;          // weight times direction, Q.14
   localparam int RGP_W  = 49;          // mass centre times weighted direction
   localparam int RG_W   = 50;          // cross product component, Q.26
   localparam int PROD_W = 51;          // rotation entry times sample
   localparam int ACC_W  = 56;          // aligned Q.28 sum
   localparam int FRAC_W = 28;
   localparam int Q_W    = ACC_W - FRAC_W;

   localparam int ADDR_W = 6;
   localparam int DATA_W = 64;

   localparam logic [2:0] REG_QUAT   = 3'd0;
   localparam logic [2:0] REG_FOFF   = 3'd1;
   localparam logic [2:0] REG_TOFF   = 3'd2;
   localparam logic [2:0] REG_MASS   = 3'd3;
   localparam logic [2:0] REG_WEIGHT = 3'd4;

   localparam logic [DATA_W-1:0] QUAT_RESET = 64'h4000_0000_0000_0000;

   typedef logic signed [SMP_W-1:0]  smp_type;
   typedef logic signed [QP_W-1:0]   qp_type;
   typedef logic signed [ROT_W-1:0]  rot_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [GW_W-1:0]   gw_type;
   typedef logic signed [RGP_W-1:0]  rgp_type;
   typedef logic signed [RG_W-1:0]   rg_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   // Round Q.28 to nearest, ties towards plus infinity, then clamp to 16 bits.
   function automatic smp_type round_sat(input acc_type v);
      acc_type t;
      logic signed [Q_W-1:0] q;
      smp_type res;
      t = v + acc_type'(64'sd134217728);
      q = t[ACC_W-1:FRAC_W];
      if (q > Q_W'(32'sd32767)) begin
         res = 16'sh7fff;
      end else if (q < Q_W'(-32'sd32768)) begin
         res = 16'sh8000;
      end else begin
         res = q[SMP_W-1:0];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ft_gravity_compensation_top.sv =====
// Top level of the force-torque gravity compensation pipeline.
`default_nettype none
// Usage
//   Request channel: drive start with a sample (req_force_*, req_torque_*) and the
//   gravity direction (req_gravity_dir_*, Q1.14). A transfer happens on every edge
//   where start is high and busy is low; busy is low whenever reset is released,
//   so one sample may enter on every clock cycle.
//   Response channel: rsp_valid marks one cycle of rsp_comp_* holding the
//   compensated wrench. The receiver cannot stall; results simply stream out.
//   Throughput is one sample per cycle. The pipeline depth from request to
//   response is set by the chain quaternion products, rotation entries,
//   rotation multiplies, aligned sum, round and clamp, each behind its own
//   register.
//   Configuration: APB-style port, 64-bit data, register i at byte address 8*i.
//   pready is tied high. Write registers only while no sample is in flight; the
//   pipeline reads them live at stages 1 and 2.
//   Reset (synchronous, active high) drops every sample in flight, restores the
//   identity rotation and clears offsets, mass centre and weight. busy is high
//   during reset so nothing is taken then.
module ft_gravity_compensation_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [15:0]            req_force_x,
   input  wire logic signed [15:0]            req_force_y,
   input  wire logic signed [15:0]            req_force_z,
   input  wire logic signed [15:0]            req_torque_x,
   input  wire logic signed [15:0]            req_torque_y,
   input  wire logic signed [15:0]            req_torque_z,
   input  wire logic signed [15:0]            req_gravity_dir_x,
   input  wire logic signed [15:0]            req_gravity_dir_y,
   input  wire logic signed [15:0]            req_gravity_dir_z,
   // response channel
   output logic                               rsp_valid,
   output logic signed [15:0]                 rsp_comp_force_x,
   output logic signed [15:0]                 rsp_comp_force_y,
   output logic signed [15:0]                 rsp_comp_force_z,
   output logic signed [15:0]                 rsp_comp_torque_x,
   output logic signed [15:0]                 rsp_comp_torque_y,
   output logic signed [15:0]                 rsp_comp_torque_z,
   // configuration port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [ftgc_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [ftgc_pkg::DATA_W-1:0]   pwdata,
   output logic [ftgc_pkg::DATA_W-1:0]        prdata,
   output logic                               pready
);

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic [63:0] quat_ff;
   logic [47:0] foff_ff;
   logic [47:0] toff_ff;
   logic [47:0] mass_ff;
   logic [15:0] weight_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = paddr[5:3];
   assign csr_wr  = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff   <= ftgc_pkg::QUAT_RESET;
         foff_ff   <= '0;
         toff_ff   <= '0;
         mass_ff   <= '0;
         weight_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            ftgc_pkg::REG_QUAT:   quat_ff   <= pwdata;
            ftgc_pkg::REG_FOFF:   foff_ff   <= pwdata[47:0];
            ftgc_pkg::REG_TOFF:   toff_ff   <= pwdata[47:0];
            ftgc_pkg::REG_MASS:   mass_ff   <= pwdata[47:0];
            ftgc_pkg::REG_WEIGHT: weight_ff <= pwdata[15:0];
            default: ;   // writes beyond the register list are dropped
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         ftgc_pkg::REG_QUAT:   prdata = quat_ff;
         ftgc_pkg::REG_FOFF:   prdata = {16'h0, foff_ff};
         ftgc_pkg::REG_TOFF:   prdata = {16'h0, toff_ff};
         ftgc_pkg::REG_MASS:   prdata = {16'h0, mass_ff};
         ftgc_pkg::REG_WEIGHT: prdata = {48'h0, weight_ff};
         default:              prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Handshake and valid chain
   // ---------------------------------------------------------------------------
   logic                             accept;
   logic [ftgc_pkg::LATENCY-1:0]     vld_ff;
   logic [ftgc_pkg::LATENCY-1:0]     vld_in;

   assign busy   = reset;
   assign accept = start & ~busy;
   assign vld_in = {vld_ff[ftgc_pkg::LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff[ftgc_pkg::LATENCY-1];

   // Operands unpacked from the configuration registers.
   ftgc_pkg::smp_type qw, qx, qy, qz;
   ftgc_pkg::smp_type foff [3];
   ftgc_pkg::smp_type toff [3];
   ftgc_pkg::smp_type mass [3];
   ftgc_pkg::smp_type smp_f [3];
   ftgc_pkg::smp_type smp_t [3];
   ftgc_pkg::smp_type smp_k [3];

   always_comb begin
      qw = quat_ff[63:48];
      qx = quat_ff[47:32];
      qy = quat_ff[31:16];
      qz = quat_ff[15:0];
      for (int i = 0; i < 3; i++) begin
         foff[i] = foff_ff[16*i +: 16];
         toff[i] = toff_ff[16*i +: 16];
         mass[i] = mass_ff[16*i +: 16];
      end
      smp_f[0] = req_force_x;
      smp_f[1] = req_force_y;
      smp_f[2] = req_force_z;
      smp_t[0] = req_torque_x;
      smp_t[1] = req_torque_y;
      smp_t[2] = req_torque_z;
      smp_k[0] = req_gravity_dir_x;
      smp_k[1] = req_gravity_dir_y;
      smp_k[2] = req_gravity_dir_z;
   end

   // ---------------------------------------------------------------------------
   // Stage 1: quaternion products, offset removal, weight times direction
   // ---------------------------------------------------------------------------
   ftgc_pkg::qp_type   s1_xx_ff, s1_yy_ff, s1_zz_ff, s1_xy_ff, s1_xz_ff, s1_yz_ff;
   ftgc_pkg::qp_type   s1_wx_ff, s1_wy_ff, s1_wz_ff;
   ftgc_pkg::qp_type   s1_xx_in, s1_yy_in, s1_zz_in, s1_xy_in, s1_xz_in, s1_yz_in;
   ftgc_pkg::qp_type   s1_wx_in, s1_wy_in, s1_wz_in;
   ftgc_pkg::diff_type s1_d_ff [3];
   ftgc_pkg::diff_type s1_e_ff [3];
   ftgc_pkg::gw_type   s1_g_ff [3];
   ftgc_pkg::diff_type s1_d_in [3];
   ftgc_pkg::diff_type s1_e_in [3];
   ftgc_pkg::gw_type   s1_g_in [3];

   always_comb begin
      s1_xx_in = ftgc_pkg::QP_W'(qx) * ftgc_pkg::QP_W'(qx);
      s1_yy_in = ftgc_pkg::QP_W'(qy) * ftgc_pkg::QP_W'(qy);
      s1_zz_in = ftgc_pkg::QP_W'(qz) * ftgc_pkg::QP_W'(qz);
      s1_xy_in = ftgc_pkg::QP_W'(qx) * ftgc_pkg::QP_W'(qy);
      s1_xz_in = ftgc_pkg::QP_W'(qx) * ftgc_pkg::QP_W'(qz);
      s1_yz_in = ftgc_pkg::QP_W'(qy) * ftgc_pkg::QP_W'(qz);
      s1_wx_in = ftgc_pkg::QP_W'(qw) * ftgc_pkg::QP_W'(qx);
      s1_wy_in = ftgc_pkg::QP_W'(qw) * ftgc_pkg::QP_W'(qy);
      s1_wz_in = ftgc_pkg::QP_W'(qw) * ftgc_pkg::QP_W'(qz);
      for (int i = 0; i < 3; i++) begin
         // full 17-bit difference, no clamping here
         s1_d_in[i] = ftgc_pkg::DIFF_W'(smp_f[i]) - ftgc_pkg::DIFF_W'(foff[i]);
         s1_e_in[i] = ftgc_pkg::DIFF_W'(smp_t[i]) - ftgc_pkg::DIFF_W'(toff[i]);
         s1_g_in[i] = ftgc_pkg::GW_W'($signed({1'b0, weight_ff}))
                    * ftgc_pkg::GW_W'(smp_k[i]);
      end
   end

   always_ff @(posedge clock) begin
      s1_xx_ff <= s1_xx_in;
      s1_yy_ff <= s1_yy_in;
      s1_zz_ff <= s1_zz_in;
      s1_xy_ff <= s1_xy_in;
      s1_xz_ff <= s1_xz_in;
      s1_yz_ff <= s1_yz_in;
      s1_wx_ff <= s1_wx_in;
      s1_wy_ff <= s1_wy_in;
      s1_wz_ff <= s1_wz_in;
      s1_d_ff  <= s1_d_in;
      s1_e_ff  <= s1_e_in;
      s1_g_ff  <= s1_g_in;
   end

   // ---------------------------------------------------------------------------
   // Stage 2: rotation matrix entries (Q.28) and cross product partials
   // ---------------------------------------------------------------------------
   localparam ftgc_pkg::rot_type ROT_ONE = 34'sd268435456;

   ftgc_pkg::rot_type  s2_rm_ff [3][3];
   ftgc_pkg::rot_type  s2_rm_in [3][3];
   ftgc_pkg::rgp_type  s2_rgp_ff [6];
   ftgc_pkg::rgp_type  s2_rgp_in [6];
   ftgc_pkg::diff_type s2_d_ff [3];
   ftgc_pkg::diff_type s2_e_ff [3];
   ftgc_pkg::gw_type   s2_g_ff [3];

   function automatic ftgc_pkg::rot_type twice_sum(input ftgc_pkg::qp_type a,
                                                   input ftgc_pkg::qp_type b);
      return (ftgc_pkg::ROT_W'(a) + ftgc_pkg::ROT_W'(b)) <<< 1;
   endfunction

   always_comb begin
      s2_rm_in[0][0] = ROT_ONE - twice_sum(s1_yy_ff, s1_zz_ff);
      s2_rm_in[0][1] = twice_sum(s1_xy_ff, -s1_wz_ff);
      s2_rm_in[0][2] = twice_sum(s1_xz_ff, s1_wy_ff);
      s2_rm_in[1][0] = twice_sum(s1_xy_ff, s1_wz_ff);
      s2_rm_in[1][1] = ROT_ONE - twice_sum(s1_xx_ff, s1_zz_ff);
      s2_rm_in[1][2] = twice_sum(s1_yz_ff, -s1_wx_ff);
      s2_rm_in[2][0] = twice_sum(s1_xz_ff, -s1_wy_ff);
      s2_rm_in[2][1] = twice_sum(s1_yz_ff, s1_wx_ff);
      s2_rm_in[2][2] = ROT_ONE - twice_sum(s1_xx_ff, s1_yy_ff);
      // r x g: pairs (a, b) for component i = a - b
      s2_rgp_in[0] = ftgc_pkg::RGP_W'(mass[1]) * ftgc_pkg::RGP_W'(s1_g_ff[2]);
      s2_rgp_in[1] = ftgc_pkg::RGP_W'(mass[2]) * ftgc_pkg::RGP_W'(s1_g_ff[1]);
      s2_rgp_in[2] = ftgc_pkg::RGP_W'(mass[2]) * ftgc_pkg::RGP_W'(s1_g_ff[0]);
      s2_rgp_in[3] = ftgc_pkg::RGP_W'(mass[0]) * ftgc_pkg::RGP_W'(s1_g_ff[2]);
      s2_rgp_in[4] = ftgc_pkg::RGP_W'(mass[0]) * ftgc_pkg::RGP_W'(s1_g_ff[1]);
      s2_rgp_in[5] = ftgc_pkg::RGP_W'(mass[1]) * ftgc_pkg::RGP_W'(s1_g_ff[0]);
   end

   always_ff @(posedge clock) begin
      s2_rm_ff  <= s2_rm_in;
      s2_rgp_ff <= s2_rgp_in;
      s2_d_ff   <= s1_d_ff;
      s2_e_ff   <= s1_e_ff;
      s2_g_ff   <= s1_g_ff;
   end

   // ---------------------------------------------------------------------------
   // Stage 3: rotate both offset-removed vectors, finish the cross product
   // ---------------------------------------------------------------------------
   ftgc_pkg::prod_type s3_fp_ff [3][3];
   ftgc_pkg::prod_type s3_tp_ff [3][3];
   ftgc_pkg::prod_type s3_fp_in [3][3];
   ftgc_pkg::prod_type s3_tp_in [3][3];
   ftgc_pkg::rg_type   s3_rg_ff [3];
   ftgc_pkg::rg_type   s3_rg_in [3];
   ftgc_pkg::gw_type   s3_g_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            s3_fp_in[i][j] = ftgc_pkg::PROD_W'(s2_rm_ff[i][j])
                           * ftgc_pkg::PROD_W'(s2_d_ff[j]);
            s3_tp_in[i][j] = ftgc_pkg::PROD_W'(s2_rm_ff[i][j])
                           * ftgc_pkg::PROD_W'(s2_e_ff[j]);
         end
         s3_rg_in[i] = ftgc_pkg::RG_W'(s2_rgp_ff[2*i]) - ftgc_pkg::RG_W'(s2_rgp_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      s3_fp_ff <= s3_fp_in;
      s3_tp_ff <= s3_tp_in;
      s3_rg_ff <= s3_rg_in;
      s3_g_ff  <= s2_g_ff;
   end

   // ---------------------------------------------------------------------------
   // Stage 4: align every term to Q.28 and sum
   // ---------------------------------------------------------------------------
   ftgc_pkg::acc_type s4_fv_ff [3];
   ftgc_pkg::acc_type s4_tv_ff [3];
   ftgc_pkg::acc_type s4_fv_in [3];
   ftgc_pkg::acc_type s4_tv_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s4_fv_in[i] = ftgc_pkg::ACC_W'(s3_fp_ff[i][0]) + ftgc_pkg::ACC_W'(s3_fp_ff[i][1])
                     + ftgc_pkg::ACC_W'(s3_fp_ff[i][2])
                     - (ftgc_pkg::ACC_W'(s3_g_ff[i]) <<< 14);
         s4_tv_in[i] = ftgc_pkg::ACC_W'(s3_tp_ff[i][0]) + ftgc_pkg::ACC_W'(s3_tp_ff[i][1])
                     + ftgc_pkg::ACC_W'(s3_tp_ff[i][2])
                     - (ftgc_pkg::ACC_W'(s3_rg_ff[i]) <<< 2);
      end
   end

   always_ff @(posedge clock) begin
      s4_fv_ff <= s4_fv_in;
      s4_tv_ff <= s4_tv_in;
   end

   // ---------------------------------------------------------------------------
   // Stage 5: round, clamp and hold the response for its strobe cycle
   // ---------------------------------------------------------------------------
   ftgc_pkg::smp_type s5_f_ff [3];
   ftgc_pkg::smp_type s5_t_ff [3];
   ftgc_pkg::smp_type s5_f_in [3];
   ftgc_pkg::smp_type s5_t_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s5_f_in[i] = ftgc_pkg::round_sat(s4_fv_ff[i]);
         s5_t_in[i] = ftgc_pkg::round_sat(s4_tv_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      s5_f_ff <= s5_f_in;
      s5_t_ff <= s5_t_in;
   end

   assign rsp_comp_force_x  = s5_f_ff[0];
   assign rsp_comp_force_y  = s5_f_ff[1];
   assign rsp_comp_force_z  = s5_f_ff[2];
   assign rsp_comp_torque_x = s5_t_ff[0];
   assign rsp_comp_torque_y = s5_t_ff[1];
   assign rsp_comp_torque_z = s5_t_ff[2];

endmodule
`default_nettype wire

// ===== rtl/core/ftgc_checker.sv =====
// Port-level checks for the gravity compensation top level, bound to it.
`default_nettype none
module ftgc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic pready
);

   // every transfer in is answered by a strobe at the end of the pipeline
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(ftgc_pkg::LATENCY) rsp_valid)
      else $error("request transfer not answered after pipeline latency");

   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, ftgc_pkg::LATENCY))
      else $error("response strobe without a matching request transfer");

   a_no_wait: assert property (@(posedge clock) disable iff (reset)
      pready && !busy)
      else $error("block stalled a port outside reset");

endmodule

bind ft_gravity_compensation_top ftgc_checker u_ftgc_checker (.*);
`default_nettype wire
